FILE: rtl/tcpsr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the text cell and pixel scanline renderer.
// No dependencies; imported by tcpsr_cfg, tcpsr_stores, tcpsr_emit and the top level.
package tcpsr_pkg;

  // Request type codes
  localparam logic [2:0] REQ_PALETTE = 3'd0;
  localparam logic [2:0] REQ_GLYPH   = 3'd1;
  localparam logic [2:0] REQ_CELL    = 3'd2;
  localparam logic [2:0] REQ_PAIR    = 3'd3;
  localparam logic [2:0] REQ_LOWRES  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_DOUBLE_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_COLOR_SEL        = 2'd1;
  localparam logic [1:0] CFG_TRANSPARENT_MASK = 2'd2;

  // Configuration reset values
  localparam logic       RST_DOUBLE_WIDTH     = 1'b1;
  localparam logic       RST_COLOR_SEL        = 1'b0;
  localparam logic [7:0] RST_TRANSPARENT_MASK = 8'h40;

  // Palette geometry
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = 8;

  // Default glyph height in rows
  localparam int GLYPH_ROWS_DEF = 8;

  // Attribute fields
  localparam int ATTR_INVERSE_BIT = 7;

  typedef struct packed {
    logic       double_width;
    logic       color_sel;
    logic [7:0] transparent_mask;
  } cfg_t;

  // Store access for one request, built from the input register
  typedef struct packed {
    logic              pal_we;
    logic              glyph_we;
    logic              rd_en;
    logic [PAL_AW-1:0] pal_waddr;
    logic [7:0]        wdata;
    logic [PAL_AW-1:0] pal_addr_a;
    logic [PAL_AW-1:0] pal_addr_b;
  } st_cmd_t;

  // What the word emitter needs to know about a request it takes on
  typedef struct packed {
    logic       load;
    logic [2:0] kind;
    logic       dbl;
  } emit_cmd_t;

  // RGB888 to RRRGGGBB
  function automatic logic [7:0] rgb332(input logic [23:0] rgb);
    rgb332 = {rgb[23:21], rgb[15:13], rgb[7:6]};
  endfunction

  // Repeat a byte into all four lanes of a word
  function automatic logic [31:0] rep4(input logic [7:0] c);
    rep4 = {c, c, c, c};
  endfunction

endpackage

FILE: rtl/tcpsr_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces: request, result and configuration write.
// Standalone; used by the top level, tcpsr_cfg and tcpsr_emit ports.
interface tcpsr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  entry_index;
  logic [2:0]  sub_row;
  logic [23:0] write_data;
  logic [7:0]  under_code;
  logic [7:0]  under_flags;
  logic [7:0]  over_code;
  logic [7:0]  over_flags;
  logic [7:0]  pixel_first;
  logic [7:0]  pixel_second;

  modport source (output valid, req_type, entry_index, sub_row, write_data, under_code,
                  under_flags, over_code, over_flags, pixel_first, pixel_second,
                  input ready);
  modport sink (input valid, req_type, entry_index, sub_row, write_data, under_code,
                under_flags, over_code, over_flags, pixel_first, pixel_second,
                output ready);
endinterface

interface tcpsr_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_word;

  modport source (output valid, out_word, last_word, input ready);
  modport sink (input valid, out_word, last_word, output ready);
endinterface

interface tcpsr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: rtl/tcpsr_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: double width, color select, transparent mask.
// Depends on tcpsr_pkg and tcpsr_cfg_if.
module tcpsr_cfg
  import tcpsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  tcpsr_cfg_if.sink   cfg,
  output cfg_t        regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.double_width     <= RST_DOUBLE_WIDTH;
      regs.color_sel        <= RST_COLOR_SEL;
      regs.transparent_mask <= RST_TRANSPARENT_MASK;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DOUBLE_WIDTH:     regs.double_width     <= cfg.wdata[0];
        CFG_COLOR_SEL:        regs.color_sel        <= cfg.wdata[0];
        CFG_TRANSPARENT_MASK: regs.transparent_mask <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tcpsr_stores.sv
`timescale 1ns / 1ps
// Palette memory (256 x 8, valid bits give the all-zero reset) and glyph
// memory (256*GLYPH_ROWS x 8). Registered reads. Depends on tcpsr_pkg.
module tcpsr_stores
  import tcpsr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
  parameter int GA_W       = $clog2(256 * GLYPH_ROWS)
) (
  input  logic            clk,
  input  logic            rst,
  input  st_cmd_t         cmd,
  input  logic [GA_W-1:0] glyph_addr,
  output logic [7:0]      glyph_row,
  output logic [7:0]      pal_a,
  output logic [7:0]      pal_b
);

  localparam int GLYPH_DEPTH = 256 * GLYPH_ROWS;

  logic [7:0]           pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] pal_vld;
  logic [7:0]           glyph_mem [GLYPH_DEPTH];
  logic [7:0]           pal_rd_a;
  logic [7:0]           pal_rd_b;
  logic                 vld_a;
  logic                 vld_b;

  // Palette array: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.pal_we) begin
      pal_mem[cmd.pal_waddr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      pal_rd_a <= pal_mem[cmd.pal_addr_a];
      pal_rd_b <= pal_mem[cmd.pal_addr_b];
    end
  end

  // Entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
    end else begin
      if (cmd.pal_we) begin
        pal_vld[cmd.pal_waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        vld_a <= pal_vld[cmd.pal_addr_a];
        vld_b <= pal_vld[cmd.pal_addr_b];
      end
    end
  end

  assign pal_a = vld_a ? pal_rd_a : 8'h00;
  assign pal_b = vld_b ? pal_rd_b : 8'h00;

  // Glyph array: single port, write or read per request
  always_ff @(posedge clk) begin
    if (cmd.glyph_we) begin
      glyph_mem[glyph_addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      glyph_row <= glyph_mem[glyph_addr];
    end
  end

endmodule

FILE: rtl/tcpsr_emit.sv
`timescale 1ns / 1ps
// Word emitter: steps through one request's words from the store read data
// and drives the output register. Depends on tcpsr_pkg and tcpsr_res_if.
module tcpsr_emit
  import tcpsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  emit_cmd_t   cmd,
  input  logic [7:0]  glyph_row,
  input  logic [7:0]  pal_a,
  input  logic [7:0]  pal_b,
  output logic        free,
  tcpsr_res_if.source res
);

  logic        busy;
  logic [2:0]  kind;
  logic        dbl;
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic        is_last;
  logic        step;
  logic [31:0] word_next;
  logic [31:0] fg;
  logic [31:0] bg;
  logic [31:0] mask;
  logic [3:0]  pos;
  logic [2:0]  bit_sel;
  logic        out_valid;
  logic [31:0] out_word;
  logic        last_word;

  // Last word of the request held here
  always_comb begin
    case (kind)
      REQ_CELL: is_last = dbl ? (cnt == 2'd3) : (cnt == 2'd1);
      default:  is_last = 1'b1;
    endcase
  end

  assign step     = busy && (!out_valid || res.ready);
  assign free     = !busy || (step && is_last);
  assign cnt_next = cnt + 2'd1;

  // Build the word at index cnt
  always_comb begin
    fg   = rep4(pal_a);
    bg   = rep4(pal_b);
    mask = '0;
    pos  = '0;
    bit_sel = '0;
    for (int p = 0; p < 4; p++) begin
      pos     = {cnt, 2'b00} + 4'(p);
      bit_sel = dbl ? pos[3:1] : pos[2:0];
      mask[p*8 +: 8] = {8{glyph_row[bit_sel]}};
    end
    case (kind)
      REQ_CELL: word_next = (fg & mask) | (bg & ~mask);
      REQ_PAIR: word_next = {pal_b, pal_b, pal_a, pal_a};
      default:  word_next = rep4(pal_a);
    endcase
  end

  // Sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (step) begin
      busy <= !is_last;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= cmd.kind;
      dbl  <= cmd.dbl;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word  <= word_next;
      last_word <= is_last;
    end
  end

  assign res.valid     = out_valid;
  assign res.out_word  = out_word;
  assign res.last_word = last_word;

endmodule

FILE: rtl/text_cell_and_pixel_scanline_renderer_top.sv
`timescale 1ns / 1ps
// Top level of the text cell and pixel scanline renderer.
// Depends on tcpsr_pkg, tcpsr_ifs, tcpsr_cfg, tcpsr_stores, tcpsr_emit.
//
//   channel  direction  carries
//   req      in         one request: write, text cell or pixel item
//   res      out        one 32-bit word of four RGB332 pixels, last marker
//   cfg      in         register index and write data
//
// Requests pass an input register, a memory read stage and an output
// register, in that order, before the first word is valid.
// Requests can follow back to back while res does not stall; the word count sets
// how long the word emitter is held: a 2x text cell gives four words, a 1x
// cell two, a pixel item one, and writes and unknown types none.
// Reset sets config to its reset values and clears palette valid bits and all handshake state.
// A stall on res backs up through the emitter to req.ready.
module text_cell_and_pixel_scanline_renderer_top
  import tcpsr_pkg::*;
#(
  parameter int GLYPH_ROWS = GLYPH_ROWS_DEF
) (
  input logic         clk,
  input logic         rst,
  tcpsr_req_if.sink   req,
  tcpsr_res_if.source res,
  tcpsr_cfg_if.sink   cfg
);

  localparam int GA_W = $clog2(256 * GLYPH_ROWS);

  cfg_t        regs;
  st_cmd_t     st_cmd;
  emit_cmd_t   em_cmd;
  logic [GA_W-1:0] glyph_addr;
  logic [7:0]  glyph_row;
  logic [7:0]  pal_a;
  logic [7:0]  pal_b;
  logic        emit_free;

  // Input register
  logic        s1_valid;
  logic [2:0]  s1_type;
  logic [7:0]  s1_entry;
  logic [2:0]  s1_sub;
  logic [23:0] s1_data;
  logic [7:0]  s1_bch;
  logic [7:0]  s1_battr;
  logic [7:0]  s1_och;
  logic [7:0]  s1_oattr;
  logic [7:0]  s1_pa;
  logic [7:0]  s1_pb;

  logic        needs_emit;
  logic        s1_adv;
  logic        accept;
  logic [7:0]  ch;
  logic [7:0]  attr;
  logic [7:0]  fgi;
  logic [7:0]  fgi_sel;
  logic [7:0]  bgi_sel;
  logic [7:0]  glyph_code;

  tcpsr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake and advance
  always_comb begin
    needs_emit = s1_type inside {REQ_CELL, REQ_PAIR, REQ_LOWRES};
  end

  assign s1_adv    = s1_valid && (!needs_emit || emit_free);
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type  <= req.req_type;
      s1_entry <= req.entry_index;
      s1_sub   <= req.sub_row;
      s1_data  <= req.write_data;
      s1_bch   <= req.under_code;
      s1_battr <= req.under_flags;
      s1_och   <= req.over_code;
      s1_oattr <= req.over_flags;
      s1_pa    <= req.pixel_first;
      s1_pb    <= req.pixel_second;
    end
  end

  // Cell layer choice and color indexes
  always_comb begin
    if ((s1_oattr & regs.transparent_mask) == 8'h00) begin
      ch   = s1_och;
      attr = s1_oattr;
    end else begin
      ch   = s1_bch;
      attr = s1_battr;
    end
    fgi = regs.color_sel ? ({5'b0, attr[2:0]} + 8'd1) : 8'd1;
    if (attr[ATTR_INVERSE_BIT]) begin
      fgi_sel = 8'd0;
      bgi_sel = fgi;
    end else begin
      fgi_sel = fgi;
      bgi_sel = 8'd0;
    end
  end

  // Store access
  assign glyph_code = (s1_type == REQ_GLYPH) ? s1_entry : ch;
  assign glyph_addr = GA_W'(glyph_code) * GA_W'(GLYPH_ROWS) + GA_W'(s1_sub);

  always_comb begin
    st_cmd.pal_we     = s1_adv && (s1_type == REQ_PALETTE);
    st_cmd.glyph_we   = s1_adv && (s1_type == REQ_GLYPH);
    st_cmd.rd_en      = s1_adv && needs_emit;
    st_cmd.pal_waddr  = s1_entry;
    st_cmd.wdata      = (s1_type == REQ_PALETTE) ? rgb332(s1_data) : s1_data[7:0];
    st_cmd.pal_addr_a = (s1_type == REQ_CELL) ? fgi_sel : s1_pa;
    st_cmd.pal_addr_b = (s1_type == REQ_CELL) ? bgi_sel : s1_pb;
  end

  tcpsr_stores #(
    .GLYPH_ROWS (GLYPH_ROWS),
    .GA_W       (GA_W)
  ) u_stores (
    .clk        (clk),
    .rst        (rst),
    .cmd        (st_cmd),
    .glyph_addr (glyph_addr),
    .glyph_row  (glyph_row),
    .pal_a      (pal_a),
    .pal_b      (pal_b)
  );

  assign em_cmd.load = st_cmd.rd_en;
  assign em_cmd.kind = s1_type;
  assign em_cmd.dbl  = regs.double_width;

  tcpsr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (em_cmd),
    .glyph_row (glyph_row),
    .pal_a     (pal_a),
    .pal_b     (pal_b),
    .free      (emit_free),
    .res       (res)
  );

endmodule
